### rtl/core/mru_move_to_front_list_unit_assert.svh
// Assertion helpers shared by the list unit RTL.
`ifndef MRU_MOVE_TO_FRONT_LIST_UNIT_ASSERT_SVH
`define MRU_MOVE_TO_FRONT_LIST_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRUL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MRUL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/mrul_pkg.sv
package mrul_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_BITS_DEF    = 32;

    localparam int CMD_W   = 2;
    localparam int FKEY_W  = 32;
    localparam int POS_W   = 4;
    localparam int CNT_FW  = 5;
    localparam int LSIZE_W = 5;

    localparam logic [LSIZE_W-1:0] LSIZE_RESET = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } mrul_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_TAIL_RD,
        ST_TAIL_CAP,
        ST_DONE
    } mrul_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [FKEY_W-1:0] item_key;
        logic [POS_W-1:0]  position;
    } mrul_in_t;

    typedef struct packed {
        logic              hit;
        logic [POS_W-1:0]  hit_position;
        logic              evicted;
        logic [FKEY_W-1:0] evicted_key;
        logic              read_valid;
        logic [FKEY_W-1:0] read_key;
        logic [CNT_FW-1:0] entry_count;
    } mrul_out_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic accept;
        logic search;
        logic setup;
        logic shift;
        logic head;
        logic tail_rd;
        logic tail_cap;
        logic load;
    } mrul_ctl_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_add;
        logic cnt_zero;
        logic srch_hit;
        logic srch_last;
        logic shift_done;
        logic need_tail;
        logic out_free;
    } mrul_sts_t;

endpackage

### rtl/core/mru_move_to_front_list_unit.sv
// Most-recently-used key list with move-to-front on add.
// Input channel in_valid/in_stall carries a command (add, read, clear), a key and a
// read position; a transfer happens on a clock edge with valid high and stall low.
// Every accepted item yields exactly one result on out_valid/out_stall: hit flag and
// position, evicted tail key, read data and the entry count after the item.
// The list size register is written through cfg_write_en/cfg_write_data; write it
// only while idle, as the block itself does not enforce this. A read, clear or blank
// add goes straight to the done state. An add walks the entry memory (one read port,
// one write port) twice, once to search and once to shift entries down, one entry
// per cycle; a hit that leaves the list above its size also reads and evicts the
// tail. One item is in flight at a time; the next item is taken at the edge where the
// previous result can first leave.
// The result sits in an output register, so a new item can be accepted while the
// previous result is still stalled; the new item then waits at its end until the
// output register frees up, and in_stall stays high meanwhile.
// Reset empties the list and sets the list size to 16; entry storage is not cleared,
// so there is no startup sweep.
module mru_move_to_front_list_unit
    import mrul_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [LSIZE_W-1:0] cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  mrul_in_t           in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output mrul_out_t          out_data
);

    mrul_ctl_t ctl;
    mrul_sts_t sts;

    mrul_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .in_stall (in_stall),
        .ctl      (ctl)
    );

    mrul_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_data        (in_data),
        .ctl            (ctl),
        .out_stall      (out_stall),
        .sts            (sts),
        .out_valid      (out_valid),
        .out_data       (out_data)
    );

endmodule

### rtl/core/mrul_ctrl.sv
module mrul_ctrl
    import mrul_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  mrul_sts_t sts,
    output logic      in_stall,
    output mrul_ctl_t ctl
);

    mrul_state_t state_reg;
    mrul_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.is_add ? ST_SEARCH : ST_DONE;
                end
            end
            ST_SEARCH:
            begin
                if (sts.srch_hit || sts.srch_last || sts.cnt_zero)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (sts.shift_done)
                begin
                    state_next = sts.need_tail ? ST_TAIL_RD : ST_DONE;
                end
            end
            ST_TAIL_RD:
            begin
                state_next = ST_TAIL_CAP;
            end
            ST_TAIL_CAP:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                ctl.accept = in_valid;
            end
            ST_SEARCH:
            begin
                if (sts.srch_hit || sts.srch_last || sts.cnt_zero)
                begin
                    ctl.setup = 1'b1;
                end
                else
                begin
                    ctl.search = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                // The head is written only after the last shifted entry has landed.
                if (sts.shift_done)
                begin
                    ctl.head = 1'b1;
                end
                else
                begin
                    ctl.shift = 1'b1;
                end
            end
            ST_TAIL_RD:
            begin
                ctl.tail_rd = 1'b1;
            end
            ST_TAIL_CAP:
            begin
                ctl.tail_cap = 1'b1;
            end
            ST_DONE:
            begin
                ctl.load = sts.out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

### rtl/core/mrul_dp.sv
`include "mru_move_to_front_list_unit_assert.svh"

module mrul_dp
    import mrul_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [LSIZE_W-1:0] cfg_write_data,
    input  mrul_in_t           in_data,
    input  mrul_ctl_t          ctl,
    input  logic               out_stall,
    output mrul_sts_t          sts,
    output logic               out_valid,
    output mrul_out_t          out_data
);

    localparam int IDX_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W     = (CNT_W > LSIZE_W) ? CNT_W : LSIZE_W;
    localparam int POS_CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);
    localparam logic [CMP_W-1:0] CMP_MAX = CMP_W'(MAX_ENTRIES);

    logic [KEY_BITS-1:0] mem [MAX_ENTRIES];

    logic [KEY_BITS-1:0] rdat_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] evkey_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    ptr_reg;
    logic [IDX_W-1:0]    pidx_reg;
    logic [IDX_W-1:0]    found_reg;
    logic [LSIZE_W-1:0]  lsize_reg;
    logic                pend_reg;
    logic                hit_reg;
    logic                ev_reg;
    logic                rvld_reg;
    logic                out_valid_reg;
    mrul_out_t           out_reg;

    logic [CMP_W-1:0]    lsz_ext;
    logic [CMP_W-1:0]    limit;
    logic [CMP_W-1:0]    cnt_ext;
    logic [CNT_W-1:0]    count_m1;
    logic [CNT_W-1:0]    ptr_m1;
    logic [KEY_BITS-1:0] in_key;
    logic [CMD_W-1:0]    in_cmd;
    logic                rd_ok;
    logic                ptr_in;
    logic                srch_match;
    logic                miss_evict;

    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [KEY_BITS-1:0] wr_data;

    // Effective list size: zero acts as one, anything above capacity as capacity.
    always_comb
    begin
        lsz_ext = CMP_W'(lsize_reg);
        if (lsz_ext == '0)
        begin
            limit = CMP_W'(1);
        end
        else if (lsz_ext > CMP_MAX)
        begin
            limit = CMP_MAX;
        end
        else
        begin
            limit = lsz_ext;
        end
    end

    assign cnt_ext    = CMP_W'(count_reg);
    assign count_m1   = count_reg - CNT_W'(1);
    assign ptr_m1     = ptr_reg - CNT_W'(1);
    assign in_key     = KEY_BITS'(in_data.item_key);
    assign in_cmd     = in_data.command;
    assign rd_ok      = POS_CMP_W'(in_data.position) < POS_CMP_W'(count_reg);
    assign ptr_in     = ptr_reg < count_reg;
    assign srch_match = pend_reg && (rdat_reg == key_reg);
    assign miss_evict = cnt_ext >= limit;

    assign sts.is_add     = (in_cmd == CMD_ADD) && (in_key != '0);
    assign sts.cnt_zero   = (count_reg == '0);
    assign sts.srch_hit   = srch_match;
    assign sts.srch_last  = pend_reg && (CNT_W'(pidx_reg) == count_m1);
    assign sts.shift_done = (ptr_reg == '0) && !pend_reg;
    assign sts.need_tail  = hit_reg && (cnt_ext > limit);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    // Single read port and single write port; the shift walk reads entry k-1
    // while the entry it read in the previous cycle is written one place further down.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = key_reg;
        if (ctl.accept && (in_cmd == CMD_READ) && rd_ok)
        begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(in_data.position);
        end
        if (ctl.search && ptr_in)
        begin
            rd_en   = 1'b1;
            rd_addr = ptr_reg[IDX_W-1:0];
        end
        if (ctl.shift)
        begin
            if (pend_reg)
            begin
                wr_en   = 1'b1;
                wr_addr = pidx_reg + IDX_W'(1);
                wr_data = rdat_reg;
            end
            if (ptr_reg != '0)
            begin
                rd_en   = 1'b1;
                rd_addr = ptr_m1[IDX_W-1:0];
            end
        end
        if (ctl.head)
        begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = key_reg;
        end
        if (ctl.tail_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = count_m1[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdat_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lsize_reg     <= LSIZE_RESET;
            count_reg     <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                lsize_reg <= cfg_write_data;
            end
            if (ctl.accept)
            begin
                pend_reg <= 1'b0;
                ptr_reg  <= '0;
                if (in_cmd == CMD_CLEAR)
                begin
                    count_reg <= '0;
                end
            end
            if (ctl.search)
            begin
                pend_reg <= ptr_in;
                if (ptr_in)
                begin
                    ptr_reg <= ptr_reg + CNT_W'(1);
                end
            end
            if (ctl.setup)
            begin
                pend_reg <= 1'b0;
                if (srch_match)
                begin
                    ptr_reg <= CNT_W'(pidx_reg);
                end
                else if (miss_evict)
                begin
                    ptr_reg <= count_m1;
                end
                else
                begin
                    ptr_reg   <= count_reg;
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (ctl.shift)
            begin
                pend_reg <= (ptr_reg != '0);
                if (ptr_reg != '0)
                begin
                    ptr_reg <= ptr_m1;
                end
            end
            if (ctl.tail_cap)
            begin
                count_reg <= count_m1;
            end
            if (ctl.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            key_reg   <= in_key;
            hit_reg   <= 1'b0;
            found_reg <= '0;
            ev_reg    <= 1'b0;
            evkey_reg <= '0;
            rvld_reg  <= (in_cmd == CMD_READ) && rd_ok;
        end
        if (ctl.search && ptr_in)
        begin
            pidx_reg <= ptr_reg[IDX_W-1:0];
        end
        if (ctl.setup)
        begin
            if (srch_match)
            begin
                hit_reg   <= 1'b1;
                found_reg <= pidx_reg;
            end
            else if (miss_evict)
            begin
                // The last compare of a miss holds the old tail, about to be overwritten.
                ev_reg    <= 1'b1;
                evkey_reg <= rdat_reg;
            end
        end
        if (ctl.shift && (ptr_reg != '0))
        begin
            pidx_reg <= ptr_m1[IDX_W-1:0];
        end
        if (ctl.tail_cap)
        begin
            ev_reg    <= 1'b1;
            evkey_reg <= rdat_reg;
        end
        if (ctl.load)
        begin
            out_reg.hit          <= hit_reg;
            out_reg.hit_position <= POS_W'(found_reg);
            out_reg.evicted      <= ev_reg;
            out_reg.evicted_key  <= FKEY_W'(evkey_reg);
            out_reg.read_valid   <= rvld_reg;
            out_reg.read_key     <= rvld_reg ? FKEY_W'(rdat_reg) : '0;
            out_reg.entry_count  <= CNT_FW'(count_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `MRUL_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_MAX, "count above capacity")
    `MRUL_ASSERT_NEXT(a_clear_empties, clk, rst_n, ctl.accept && (in_cmd == CMD_CLEAR), count_reg == '0, "clear left entries")
    `MRUL_ASSERT_IMPL(a_head_no_pending, clk, rst_n, ctl.head, !pend_reg, "head write collides with shift")
    `MRUL_ASSERT_IMPL(a_search_range, clk, rst_n, ctl.search && pend_reg, CNT_W'(pidx_reg) < count_reg, "search past tail")

endmodule
